// ===== hdl/rpmc_pkg.sv =====
// shared constants, widths and the arctangent table for the point to map cell block
// no dependencies; imported by every module of the block

package rpmc_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int INDEX_BITS   = 12;
	localparam int CORDIC_STEPS = 24;

	localparam int POINT_BITS = 32;
	localparam int CPM_BITS   = 16;
	localparam int TURN_BITS  = 32;
	localparam int ROT_BITS   = 36;
	localparam int GAIN_BITS  = 30;
	localparam int MUL_LO_BITS = 18;
	localparam int SCALE_FRAC = 24;
	localparam int SCALE_BITS = ROT_BITS + CPM_BITS + 1;

	localparam int REG_INDEX_BITS = 3;
	localparam int WR_DATA_BITS   = 32;
	localparam int IN_TDATA_BITS  = 2 * POINT_BITS;
	localparam int OUT_TDATA_BITS = ((2 * INDEX_BITS + 7) / 8) * 8;

	localparam logic [GAIN_BITS-1:0] GAIN_INV = GAIN_BITS'(32'h26DD3B6A);
	localparam logic [CPM_BITS-1:0]  CPM_RESET = CPM_BITS'(5120);
	localparam logic [INDEX_BITS-1:0] MAP_SIZE_RESET = INDEX_BITS'(701);

	localparam logic [TURN_BITS-1:0] TURN_QUARTER = TURN_BITS'(64'h4000_0000);
	localparam logic [TURN_BITS-1:0] TURN_HALF    = TURN_BITS'(64'h8000_0000);
	localparam logic [TURN_BITS-1:0] TURN_3QUARTER = TURN_BITS'(64'hC000_0000);

	localparam logic [REG_INDEX_BITS-1:0] REG_POSE_X     = 3'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_POSE_Y     = 3'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_HEADING    = 3'd2;
	localparam logic [REG_INDEX_BITS-1:0] REG_CPM        = 3'd3;
	localparam logic [REG_INDEX_BITS-1:0] REG_MAP_WIDTH  = 3'd4;
	localparam logic [REG_INDEX_BITS-1:0] REG_MAP_HEIGHT = 3'd5;

	// arctangent of 2^-i as a 32-bit turn fraction
	function automatic logic [TURN_BITS-1:0] atan_turn(input logic [4:0] i);
		logic [TURN_BITS-1:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/robot_point_to_map_cell_top.sv =====
// Robot point to map cell. Each word on the slave stream is a robot-frame point in
// signed Q16.16 metres; it is rotated by the programmed heading with a 24-stage
// cordic, offset by the programmed robot position and scaled by cells per metre into
// a clamped map column and row. One point is taken every clock cycle while the output
// is not stalled; the pipeline has one fold stage, 24 cordic stages and six stages of
// gain multiply, pose add, scaling and clamping. The whole pipeline holds while the
// output word waits on m_axis_tready. Program the registers only while no point
// is in flight.
// depends on rpmc_pkg, rpmc_cordic, rpmc_cell

module robot_point_to_map_cell_top
	import rpmc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [REG_INDEX_BITS-1:0] wr_index,
	input  logic [WR_DATA_BITS-1:0]   wr_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // point_x, point_y
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // map_col, map_row
);

	logic signed [POINT_BITS-1:0] pose_x_q;
	logic signed [POINT_BITS-1:0] pose_y_q;
	logic [ANGLE_BITS-1:0]        heading_q;
	logic [CPM_BITS-1:0]          cpm_q;
	logic [INDEX_BITS-1:0]        map_width_q;
	logic [INDEX_BITS-1:0]        map_height_q;

	logic                         en;
	logic                         rot_vld;
	logic signed [ROT_BITS-1:0]   rot_x;
	logic signed [ROT_BITS-1:0]   rot_y;
	logic                         col_vld;
	logic                         row_vld;
	logic [INDEX_BITS-1:0]        map_col;
	logic [INDEX_BITS-1:0]        map_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			heading_q    <= '0;
			cpm_q        <= CPM_RESET;
			map_width_q  <= MAP_SIZE_RESET;
			map_height_q <= MAP_SIZE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_POSE_X:     pose_x_q     <= signed'(wr_data[POINT_BITS-1:0]);
				REG_POSE_Y:     pose_y_q     <= signed'(wr_data[POINT_BITS-1:0]);
				REG_HEADING:    heading_q    <= wr_data[ANGLE_BITS-1:0];
				REG_CPM:        cpm_q        <= wr_data[CPM_BITS-1:0];
				REG_MAP_WIDTH:  map_width_q  <= wr_data[INDEX_BITS-1:0];
				REG_MAP_HEIGHT: map_height_q <= wr_data[INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	rpmc_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (s_axis_tvalid),
		.x_in    (signed'(s_axis_tdata[POINT_BITS-1:0])),
		.y_in    (signed'(s_axis_tdata[2*POINT_BITS-1:POINT_BITS])),
		.heading (heading_q),
		.vld_out (rot_vld),
		.x_out   (rot_x),
		.y_out   (rot_y)
	);

	// column follows world y, row follows world x
	rpmc_cell u_col (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (rot_vld),
		.rot     (rot_y),
		.pose    (pose_y_q),
		.cpm     (cpm_q),
		.size    (map_width_q),
		.vld_out (col_vld),
		.idx     (map_col)
	);

	rpmc_cell u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (rot_vld),
		.rot     (rot_x),
		.pose    (pose_x_q),
		.cpm     (cpm_q),
		.size    (map_height_q),
		.vld_out (row_vld),
		.idx     (map_row)
	);

	assign m_axis_tvalid = col_vld && row_vld;
	assign m_axis_tdata  = OUT_TDATA_BITS'({map_row, map_col});

endmodule

// ===== hdl/rpmc_cordic.sv =====
// pipelined cordic rotator: quadrant fold stage then one iteration per stage
// depends on rpmc_pkg

module rpmc_cordic
	import rpmc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic signed [POINT_BITS-1:0] x_in,
	input  logic signed [POINT_BITS-1:0] y_in,
	input  logic [ANGLE_BITS-1:0]        heading,
	output logic                         vld_out,
	output logic signed [ROT_BITS-1:0]   x_out,
	output logic signed [ROT_BITS-1:0]   y_out
);

	logic signed [ROT_BITS-1:0]  cx_s [0:CORDIC_STEPS];
	logic signed [ROT_BITS-1:0]  cy_s [0:CORDIC_STEPS];
	logic signed [TURN_BITS-1:0] cz_s [0:CORDIC_STEPS];
	logic                        vld_s [0:CORDIC_STEPS];

	logic [TURN_BITS-1:0]        turn;
	logic                        fold;
	logic signed [ROT_BITS-1:0]  x_ext;
	logic signed [ROT_BITS-1:0]  y_ext;

	assign turn  = {heading, {(TURN_BITS - ANGLE_BITS){1'b0}}};
	assign fold  = (turn > TURN_QUARTER) && (turn < TURN_3QUARTER);
	assign x_ext = ROT_BITS'(x_in);
	assign y_ext = ROT_BITS'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int k = 0; k < CORDIC_STEPS; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	// fold the angle into plus or minus a quarter turn by negating the vector
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= fold ? -x_ext : x_ext;
			cy_s[0] <= fold ? -y_ext : y_ext;
			cz_s[0] <= signed'(fold ? turn - TURN_HALF : turn);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		logic signed [ROT_BITS-1:0]  dx;
		logic signed [ROT_BITS-1:0]  dy;
		logic signed [TURN_BITS-1:0] da;

		assign dx = cx_s[i] >>> i;
		assign dy = cy_s[i] >>> i;
		assign da = signed'(atan_turn(5'(i)));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][TURN_BITS-1]) begin
					cx_s[i+1] <= cx_s[i] - dy;
					cy_s[i+1] <= cy_s[i] + dx;
					cz_s[i+1] <= cz_s[i] - da;
				end else begin
					cx_s[i+1] <= cx_s[i] + dy;
					cy_s[i+1] <= cy_s[i] - dx;
					cz_s[i+1] <= cz_s[i] + da;
				end
			end
		end
	end

	assign vld_out = vld_s[CORDIC_STEPS];
	assign x_out   = cx_s[CORDIC_STEPS];
	assign y_out   = cy_s[CORDIC_STEPS];

endmodule

// ===== hdl/rpmc_cell.sv =====
// one axis of the cell lookup: gain removal, pose offset, scaling and clamped index
// depends on rpmc_pkg

module rpmc_cell
	import rpmc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic signed [ROT_BITS-1:0]   rot,
	input  logic signed [POINT_BITS-1:0] pose,
	input  logic [CPM_BITS-1:0]          cpm,
	input  logic [INDEX_BITS-1:0]        size,
	output logic                         vld_out,
	output logic [INDEX_BITS-1:0]        idx
);

	localparam int HI_BITS   = ROT_BITS - MUL_LO_BITS;
	localparam int PROD_BITS = ROT_BITS + GAIN_BITS + 1;
	localparam int Q_BITS    = SCALE_BITS - 1 - SCALE_FRAC;

	logic signed [HI_BITS+GAIN_BITS:0]     ph_s1;
	logic [MUL_LO_BITS+GAIN_BITS-1:0]      pl_s1;
	logic signed [ROT_BITS-1:0]            xr_s2;
	logic signed [ROT_BITS-1:0]            world_s3;
	logic signed [SCALE_BITS-1:0]          scaled_s4;
	logic signed [SCALE_BITS-1:0]          d_s5;
	logic [5:0]                            vld_q;

	logic signed [PROD_BITS-1:0]           prod;
	logic [INDEX_BITS-1:0]                 half;
	logic signed [SCALE_BITS-1:0]          center;
	logic [Q_BITS-1:0]                     q;
	logic [INDEX_BITS-1:0]                 top;

	always_comb begin
		prod = (PROD_BITS'(ph_s1) <<< MUL_LO_BITS)
			+ PROD_BITS'(signed'({1'b0, pl_s1}))
			+ (PROD_BITS'(1) <<< (GAIN_BITS - 1));
	end

	assign half   = size >> 1;
	assign center = SCALE_BITS'(signed'({1'b0, half})) <<< SCALE_FRAC;
	assign q      = d_s5[SCALE_BITS-2:SCALE_FRAC];
	assign top    = (size == '0) ? '0 : size - INDEX_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// gain product split in two partial products
			ph_s1     <= signed'(rot[ROT_BITS-1:MUL_LO_BITS]) * signed'({1'b0, GAIN_INV});
			pl_s1     <= rot[MUL_LO_BITS-1:0] * GAIN_INV;
			xr_s2     <= prod[GAIN_BITS +: ROT_BITS];
			world_s3  <= xr_s2 + ROT_BITS'(pose);
			scaled_s4 <= world_s3 * signed'({1'b0, cpm});
			d_s5      <= center - scaled_s4 - (SCALE_BITS'(1) <<< (SCALE_FRAC - 1));
			if (d_s5[SCALE_BITS-1]) begin
				idx <= '0;
			end else if (q > Q_BITS'(top)) begin
				idx <= top;
			end else begin
				idx <= q[INDEX_BITS-1:0];
			end
		end
	end

	assign vld_out = vld_q[5];

endmodule

// ===== hdl/rpmc_checker.sv =====
// port-level checks for the point to map cell block, bound to the top level
// depends on rpmc_pkg and robot_point_to_map_cell_top

module rpmc_checker
	import rpmc_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      wr_en,
	input logic [REG_INDEX_BITS-1:0] wr_index,
	input logic [WR_DATA_BITS-1:0]   wr_data,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

	logic [INDEX_BITS-1:0] width_q;
	logic [INDEX_BITS-1:0] height_q;
	logic [INDEX_BITS-1:0] col_top;
	logic [INDEX_BITS-1:0] row_top;
	logic                  in_seen;

	// mirror of the map size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAP_SIZE_RESET;
			height_q <= MAP_SIZE_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAP_WIDTH:  width_q  <= wr_data[INDEX_BITS-1:0];
				REG_MAP_HEIGHT: height_q <= wr_data[INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign col_top = (width_q == '0) ? '0 : width_q - INDEX_BITS'(1);
	assign row_top = (height_q == '0) ? '0 : height_q - INDEX_BITS'(1);
	assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input held off without an output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output word changed");

	a_col_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[INDEX_BITS-1:0] <= col_top))
		else $error("column beyond map width");

	a_row_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2*INDEX_BITS-1:INDEX_BITS] <= row_top))
		else $error("row beyond map height");

	a_no_stall_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_seen && m_axis_tvalid) |-> m_axis_tready)
		else $error("word accepted while output stalled");

endmodule

bind robot_point_to_map_cell_top rpmc_checker u_rpmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.wr_en         (wr_en),
	.wr_index      (wr_index),
	.wr_data       (wr_data),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
